@@ design/qev_pkg.sv @@
// shared types and constants of the encoder position and velocity estimator
package qev_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STALL_TIMEOUT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_COUNT_CHANGE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_PERIOD     = 2'd2;

    localparam int CFG_W = 16;
    localparam logic [CFG_W-1:0] STALL_TIMEOUT_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] MIN_COUNT_CHANGE_RST = 16'd0;
    localparam logic [CFG_W-1:0] TIMER_PERIOD_RST     = 16'd65535;

    // field widths
    localparam int TIMER_W  = 16;
    localparam int TICK_W   = 32;
    localparam int POS_W    = 32;
    localparam int VEL_W    = 48;
    localparam int FRAC_W   = 16;
    localparam int OUT_DATA_W = 88;

    // request to the interval window memory
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } win_req_t;

    // status of the serial divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

@@ design/qev_window.sv @@
// interval window memory with per-entry valid bits, registered read
module qev_window #(
    parameter int WINDOW_LEN = 8,
    parameter int SLOT_W     = 3
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qev_pkg::win_req_t           req,
    input  logic [SLOT_W-1:0]           addr,
    input  logic [qev_pkg::TICK_W-1:0]  wr_data,
    output logic [qev_pkg::TICK_W-1:0]  rd_data
);

    logic [qev_pkg::TICK_W-1:0] mem [WINDOW_LEN];
    logic [WINDOW_LEN-1:0]      valid_reg;
    logic [qev_pkg::TICK_W-1:0] rd_data_reg;
    logic                       rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ design/qev_divider.sv @@
// restoring divider, one quotient bit per cycle
module qev_divider #(
    parameter int DW = 52,
    parameter int VW = 35
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DW-1:0]        dividend,
    input  logic [VW-1:0]        divisor,
    output logic [DW-1:0]        quotient,
    output qev_pkg::div_stat_t   stat
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg, rem_next;
    logic [DW-1:0] num_reg, num_next;
    logic [VW-1:0] divisor_reg, divisor_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [VW:0]   trial;
    logic [VW:0]   diff;

    always_comb
    begin
        trial        = {rem_reg, num_reg[DW-1]};
        diff         = trial - {1'b0, divisor_reg};
        rem_next     = rem_reg;
        num_next     = num_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (start)
        begin
            rem_next     = '0;
            num_next     = dividend;
            divisor_next = divisor;
            cnt_next     = CW'(DW);
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            // no borrow means the divisor fits
            if (!diff[VW])
            begin
                rem_next = diff[VW-1:0];
                num_next = {num_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VW-1:0];
                num_next = {num_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        num_reg     <= num_next;
        divisor_reg <= divisor_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign quotient  = num_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

@@ design/quadrature_encoder_velocity_estimator_core.sv @@
// encoder position and velocity estimator, top level with tick sequencer
//
//  channel   | direction | contents
//  s_axis    | in        | tdata: timer_count; tuser: overflow_flag
//  m_axis    | out       | tdata: position, velocity, clear_overflow; tuser: updated
//  cfg       | in        | register index and 16-bit write data, always ready
//
// a tick without update passes the eval and output states; one with update also the
// window and prep states and, for a nonzero window total, the bit-serial divider that
// forms the velocity quotient; s_axis_tready rises in the cycle the result is offered
// s_axis_tready is high only in the idle state; a stalled m_axis holds the
// finished result and the sequencer waits in its output state
// reset clears the control state and loads the config defaults, the interval window reads as zero until written
module quadrature_encoder_velocity_estimator_core #(
    parameter int WINDOW_LEN = 8,
    parameter int COUNT_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // [15:0] timer_count
    input  logic [15:0]                       s_axis_tdata,
    // [0] overflow_flag
    input  logic [0:0]                        s_axis_tuser,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [31:0] position, [79:32] velocity, [80] clear_overflow, [87:81] zero
    output logic [qev_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] updated
    output logic [0:0]                        m_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [qev_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [qev_pkg::CFG_W-1:0]         cfg_data
);

    localparam int CNT_W  = (COUNT_BITS < qev_pkg::TIMER_W) ? COUNT_BITS : qev_pkg::TIMER_W;
    localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int TOT_W  = qev_pkg::TICK_W + $clog2(WINDOW_LEN);
    localparam int DW     = qev_pkg::VEL_W + $clog2(WINDOW_LEN + 1);
    localparam int PAD_W  = qev_pkg::OUT_DATA_W - qev_pkg::POS_W - qev_pkg::VEL_W - 1;
    localparam logic [DW-1:0] WIN_MULT = DW'(WINDOW_LEN);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
    localparam logic [qev_pkg::VEL_W-1:0] VEL_POS_LIM = {1'b0, {(qev_pkg::VEL_W-1){1'b1}}};
    localparam logic [qev_pkg::VEL_W-1:0] VEL_NEG_LIM = {1'b1, {(qev_pkg::VEL_W-1){1'b0}}};

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_WIN  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [qev_pkg::CFG_W-1:0]    stall_timeout_reg, min_count_change_reg, timer_period_reg;
    logic [CNT_W-1:0]             cnt_reg, cnt_next;
    logic                         ovf_reg, ovf_next;
    logic [qev_pkg::TICK_W-1:0]   ticks_reg, ticks_next;
    logic [CNT_W-1:0]             last_count_reg, last_count_next;
    logic [qev_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic [qev_pkg::POS_W-1:0]    last_pos_reg, last_pos_next;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [TOT_W-1:0]             total_reg, total_next;
    logic [qev_pkg::VEL_W-1:0]    vel_reg, vel_next;
    logic [qev_pkg::POS_W-1:0]    mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic                         upd_reg, upd_next;
    logic                         clr_reg, clr_next;
    logic                         out_valid_reg, out_valid_next;
    logic [qev_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                         out_user_reg, out_user_next;

    qev_pkg::win_req_t            win_req;
    logic [qev_pkg::TICK_W-1:0]   win_rd_data;
    logic                         div_start;
    logic [DW-1:0]                div_dividend;
    logic [DW-1:0]                div_quotient;
    qev_pkg::div_stat_t           div_stat;

    logic                         in_req;
    logic [qev_pkg::TICK_W-1:0]   ticks_inc;
    logic [CNT_W-1:0]             absdiff;
    logic [qev_pkg::TIMER_W:0]    last_dbl;
    logic [qev_pkg::POS_W-1:0]    pos_diff;
    logic [qev_pkg::VEL_W-1:0]    vel_lim;
    logic [qev_pkg::VEL_W-1:0]    q_sat;

    assign in_req        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign cfg_ready     = 1'b1;

    qev_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .SLOT_W     (SLOT_W)
    ) u_window (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (win_req),
        .addr    (slot_reg),
        .wr_data (ticks_reg),
        .rd_data (win_rd_data)
    );

    qev_divider #(
        .DW (DW),
        .VW (TOT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (total_reg),
        .quotient (div_quotient),
        .stat     (div_stat)
    );

    // position change scaled to Q32.16 and by the window length
    assign div_dividend = DW'({mag_reg, {qev_pkg::FRAC_W{1'b0}}}) * WIN_MULT;
    assign div_start    = (state_reg == S_PREP) && (total_reg != '0);
    assign win_req.rd_en = in_req;
    assign win_req.wr_en = (state_reg == S_WIN);

    always_comb
    begin
        ticks_inc = (ticks_reg == '1) ? ticks_reg : ticks_reg + 1'b1;
        absdiff   = (cnt_reg >= last_count_reg) ? cnt_reg - last_count_reg
                                                : last_count_reg - cnt_reg;
        last_dbl  = (qev_pkg::TIMER_W + 1)'(last_count_reg) << 1;
        pos_diff  = pos_reg - last_pos_reg;
        vel_lim   = neg_reg ? VEL_NEG_LIM : VEL_POS_LIM;
        q_sat     = (div_quotient > DW'(vel_lim)) ? vel_lim
                                                  : div_quotient[qev_pkg::VEL_W-1:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        ovf_next        = ovf_reg;
        ticks_next      = ticks_reg;
        last_count_next = last_count_reg;
        pos_next        = pos_reg;
        last_pos_next   = last_pos_reg;
        slot_next       = slot_reg;
        total_next      = total_reg;
        vel_next        = vel_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        upd_next        = upd_reg;
        clr_next        = clr_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_req)
                begin
                    cnt_next   = s_axis_tdata[CNT_W-1:0];
                    ovf_next   = s_axis_tuser[0];
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                ticks_next = ticks_inc;
                if (ticks_inc > qev_pkg::TICK_W'(stall_timeout_reg))
                begin
                    vel_next = '0;
                end
                if (qev_pkg::CFG_W'(absdiff) > min_count_change_reg)
                begin
                    upd_next = 1'b1;
                    clr_next = ovf_reg;
                    if (ovf_reg)
                    begin
                        if (last_dbl >= (qev_pkg::TIMER_W + 1)'(timer_period_reg))
                        begin
                            pos_next = pos_reg + 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + qev_pkg::POS_W'(cnt_reg)
                                 - qev_pkg::POS_W'(last_count_reg);
                    end
                    state_next = S_WIN;
                end
                else
                begin
                    upd_next   = 1'b0;
                    clr_next   = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_WIN:
            begin
                // oldest interval leaves, newest enters
                total_next      = total_reg - TOT_W'(win_rd_data) + TOT_W'(ticks_reg);
                slot_next       = (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                neg_next        = pos_diff[qev_pkg::POS_W-1];
                mag_next        = pos_diff[qev_pkg::POS_W-1] ? (~pos_diff) + 1'b1 : pos_diff;
                last_pos_next   = pos_reg;
                last_count_next = cnt_reg;
                ticks_next      = '0;
                state_next      = S_PREP;
            end
            S_PREP:
            begin
                if (total_reg == '0)
                begin
                    vel_next   = '0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    vel_next   = neg_reg ? (~q_sat) + 1'b1 : q_sat;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {{PAD_W{1'b0}}, clr_reg, vel_reg, pos_reg};
                    out_user_next  = upd_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cnt_reg       <= cnt_next;
        ovf_reg       <= ovf_next;
        mag_reg       <= mag_next;
        neg_reg       <= neg_next;
        upd_reg       <= upd_next;
        clr_reg       <= clr_next;
        out_data_reg  <= out_data_next;
        out_user_reg  <= out_user_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg            <= S_IDLE;
            stall_timeout_reg    <= qev_pkg::STALL_TIMEOUT_RST;
            min_count_change_reg <= qev_pkg::MIN_COUNT_CHANGE_RST;
            timer_period_reg     <= qev_pkg::TIMER_PERIOD_RST;
            ticks_reg            <= '0;
            last_count_reg       <= '0;
            pos_reg              <= '0;
            last_pos_reg         <= '0;
            slot_reg             <= '0;
            total_reg            <= '0;
            vel_reg              <= '0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ticks_reg      <= ticks_next;
            last_count_reg <= last_count_next;
            pos_reg        <= pos_next;
            last_pos_reg   <= last_pos_next;
            slot_reg       <= slot_next;
            total_reg      <= total_next;
            vel_reg        <= vel_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    qev_pkg::CFG_STALL_TIMEOUT:    stall_timeout_reg    <= cfg_data;
                    qev_pkg::CFG_MIN_COUNT_CHANGE: min_count_change_reg <= cfg_data;
                    qev_pkg::CFG_TIMER_PERIOD:     timer_period_reg     <= cfg_data;
                    default:                       ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule
